// ===== hw/rtl/ddo_pkg.sv =====
package ddo_pkg;

    localparam int SCALE_W      = 20;
    localparam int OP_W         = 2;
    localparam int ANGLE_W      = 32;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int TRIG_SHIFT   = 8;
    localparam int TRIG_W       = CORDIC_W - TRIG_SHIFT;
    localparam int MUL_W        = TRIG_W;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DIST_LO_W    = 24;
    localparam int TURN_SHIFT   = 16;
    localparam int DELTA_SHIFT  = 38;

    localparam logic [SCALE_W-1:0] TURN_SCALE_RESET = 20'd159661;
    localparam logic [SCALE_W-1:0] DIST_SCALE_RESET = 20'd127136;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_RETRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_HEADING = 2'd2;

    localparam logic CFG_TURN_SCALE = 1'b0;
    localparam logic CFG_DIST_SCALE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN,
        ST_HEAD,
        ST_DIST,
        ST_ROT,
        ST_XLO,
        ST_XHI,
        ST_XACC,
        ST_XUPD,
        ST_YLO,
        ST_YHI,
        ST_YACC,
        ST_YUPD,
        ST_OUT
    } t_state;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ITER_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051D;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2E;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517C;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A2F;
            5'd19:   v = 32'h0000_0517;
            5'd20:   v = 32'h0000_028B;
            5'd21:   v = 32'h0000_0145;
            5'd22:   v = 32'h0000_00A2;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ddo_mul.sv =====
module ddo_mul (
    input  logic                                i_clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]    i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]    i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]   o_p
);
    import ddo_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
module ddo_cordic #(
    parameter int HEADING_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [HEADING_BITS-1:0]             i_heading,
    output logic                                o_done,
    output logic signed [ddo_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [ddo_pkg::TRIG_W-1:0]   o_sin
);
    import ddo_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [ITER_W-1:0]          r_iter;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic                       r_flip;

    logic [ANGLE_W-1:0]         angle;
    logic [ANGLE_W-1:0]         angle_q;
    logic                       flip;
    logic [ANGLE_W-1:0]         angle_r;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] da;
    logic signed [CORDIC_W-1:0] x_out;
    logic signed [CORDIC_W-1:0] y_out;

    // Headings in the left half plane are turned by half a turn so that the
    // rotation starts within its range of convergence.
    always_comb begin
        angle   = ANGLE_W'(i_heading) << (ANGLE_W - HEADING_BITS);
        angle_q = angle + QUARTER_TURN;
        flip    = angle_q[ANGLE_W-1];
        angle_r = {angle[ANGLE_W-1] ^ flip, angle[ANGLE_W-2:0]};
    end

    always_comb begin
        dx = r_y >>> r_iter;
        dy = r_x >>> r_iter;
        da = CORDIC_W'(atan_angle(r_iter));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= CORDIC_W'(signed'(angle_r));
            r_flip <= flip;
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    always_comb begin
        x_out = r_flip ? -r_x : r_x;
        y_out = r_flip ? -r_y : r_y;
    end

    assign o_done = r_done;
    assign o_cos  = x_out[CORDIC_W-1:TRIG_SHIFT];
    assign o_sin  = y_out[CORDIC_W-1:TRIG_SHIFT];

endmodule

// ===== hw/rtl/differential_drive_odometry.sv =====
// For the two position modes, the result follows an input transfer through the 24 rotations
// of the CORDIC unit and its done strobe, six passes through the shared multiplier and the two
// position updates; a heading-only update skips the rotation and the position steps. One item
// is processed at a time. Synchronous active-low reset clears the pose, loads the default
// scale factors and empties the output.
module differential_drive_odometry #(
    parameter int HEADING_BITS  = 16,
    parameter int POSITION_BITS = 32,
    parameter int TICK_BITS     = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic                                         i_cfg_index,
    input  logic [ddo_pkg::SCALE_W-1:0]                  i_cfg_data,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // left_ticks, right_ticks
    input  logic [((2*TICK_BITS+7)/8)*8-1:0]             i_s_axis_tdata,
    // operation
    input  logic [ddo_pkg::OP_W-1:0]                     i_s_axis_tuser,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // x_position, y_position, heading
    output logic [((2*POSITION_BITS+HEADING_BITS+7)/8)*8-1:0] o_m_axis_tdata
);
    import ddo_pkg::*;

    localparam int OUT_W  = ((2 * POSITION_BITS + HEADING_BITS + 7) / 8) * 8;
    localparam int SUM_W  = TICK_BITS + 1;
    localparam int DIST_W = TICK_BITS + SCALE_W + 2;
    localparam int HI_W   = DIST_W - DIST_LO_W;
    localparam int ACC_W  = DIST_W + TRIG_W;
    localparam int DEL_W  = ACC_W - DELTA_SHIFT;
    localparam int UPD_W  = ((POSITION_BITS > DEL_W) ? POSITION_BITS : DEL_W) + 2;

    localparam logic signed [ACC_W-1:0] DELTA_ROUND =
        {{(ACC_W - DELTA_SHIFT){1'b0}}, 1'b1, {(DELTA_SHIFT - 1){1'b0}}};
    localparam logic signed [PROD_W-1:0] TURN_ROUND = PROD_W'(32'sd32768);

    t_state r_state;
    t_state n_state;

    logic [SCALE_W-1:0]              r_turn_scale;
    logic [SCALE_W-1:0]              r_dist_scale;
    logic signed [SUM_W-1:0]         r_sum;
    logic signed [SUM_W-1:0]         r_diff;
    logic [OP_W-1:0]                 r_op;
    logic signed [DIST_W-1:0]        r_dist;
    logic signed [ACC_W-1:0]         r_acc;
    logic signed [POSITION_BITS-1:0] r_pos_x;
    logic signed [POSITION_BITS-1:0] r_pos_y;
    logic [HEADING_BITS-1:0]         r_heading;
    logic                            r_m_valid;
    logic [OUT_W-1:0]                r_m_tdata;

    logic                            accept;
    logic                            move;
    logic                            out_load;
    logic                            cordic_start;
    logic                            cordic_done;
    logic signed [TRIG_W-1:0]        trig_cos;
    logic signed [TRIG_W-1:0]        trig_sin;
    logic signed [MUL_W-1:0]         mul_a;
    logic signed [MUL_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]        prod;
    logic signed [TICK_BITS-1:0]     left_ticks;
    logic signed [TICK_BITS-1:0]     right_ticks;
    logic signed [HI_W-1:0]          dist_hi;
    logic signed [PROD_W-1:0]        turn_sum;
    logic signed [DEL_W-1:0]         delta;
    logic                            upd_y;
    logic                            upd_sub;
    logic signed [POSITION_BITS-1:0] upd_pos;
    logic signed [UPD_W-1:0]         upd_ext;
    logic signed [UPD_W-1:0]         upd_sum;
    logic                            upd_ovf;
    logic signed [POSITION_BITS-1:0] upd_sat;

    assign accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign left_ticks  = i_s_axis_tdata[TICK_BITS-1:0];
    assign right_ticks = i_s_axis_tdata[2*TICK_BITS-1:TICK_BITS];
    assign move        = (r_op == OP_ADVANCE) || (r_op == OP_RETRACT);
    assign dist_hi     = r_dist[DIST_W-1:DIST_LO_W];
    assign turn_sum    = prod + TURN_ROUND;
    assign delta       = r_acc[ACC_W-1:DELTA_SHIFT];

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    ddo_cordic #(
        .HEADING_BITS (HEADING_BITS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cordic_start),
        .i_heading (r_heading),
        .o_done    (cordic_done),
        .o_cos     (trig_cos),
        .o_sin     (trig_sin)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_TURN;
            ST_TURN: n_state = ST_HEAD;
            ST_HEAD: n_state = move ? ST_DIST : ST_OUT;
            ST_DIST: n_state = ST_ROT;
            ST_ROT:  if (cordic_done) n_state = ST_XLO;
            ST_XLO:  n_state = ST_XHI;
            ST_XHI:  n_state = ST_XACC;
            ST_XACC: n_state = ST_XUPD;
            ST_XUPD: n_state = ST_YLO;
            ST_YLO:  n_state = ST_YHI;
            ST_YHI:  n_state = ST_YACC;
            ST_YACC: n_state = ST_YUPD;
            ST_YUPD: n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier and strobes for each step.
    always_comb begin
        o_s_axis_tready = 1'b0;
        cordic_start    = 1'b0;
        out_load        = 1'b0;
        upd_y           = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_TURN: begin
                mul_a = MUL_W'(r_diff);
                mul_b = MUL_W'(r_turn_scale);
            end
            ST_HEAD: begin
                mul_a = MUL_W'(r_sum);
                mul_b = MUL_W'(r_dist_scale);
            end
            ST_DIST: cordic_start = 1'b1;
            ST_XLO: begin
                mul_a = MUL_W'(r_dist[DIST_LO_W-1:0]);
                mul_b = trig_cos;
            end
            ST_XHI: begin
                mul_a = MUL_W'(dist_hi);
                mul_b = trig_cos;
            end
            ST_YLO: begin
                mul_a = MUL_W'(r_dist[DIST_LO_W-1:0]);
                mul_b = trig_sin;
            end
            ST_YHI: begin
                mul_a = MUL_W'(dist_hi);
                mul_b = trig_sin;
            end
            ST_YUPD: upd_y = 1'b1;
            ST_OUT:  out_load = !r_m_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    // The y axis takes the negated sine, so its sense of addition is reversed.
    always_comb begin
        upd_sub = (r_op == OP_RETRACT) ^ upd_y;
        upd_pos = upd_y ? r_pos_y : r_pos_x;
        upd_ext = UPD_W'(delta);
        upd_sum = UPD_W'(upd_pos) + (upd_sub ? -upd_ext : upd_ext);
        upd_ovf = !((&upd_sum[UPD_W-1:POSITION_BITS-1]) || !(|upd_sum[UPD_W-1:POSITION_BITS-1]));
        if (upd_ovf) begin
            upd_sat = upd_sum[UPD_W-1] ? {1'b1, {(POSITION_BITS - 1){1'b0}}}
                                       : {1'b0, {(POSITION_BITS - 1){1'b1}}};
        end else begin
            upd_sat = upd_sum[POSITION_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_turn_scale <= TURN_SCALE_RESET;
            r_dist_scale <= DIST_SCALE_RESET;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_heading    <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TURN_SCALE: r_turn_scale <= i_cfg_data;
                    CFG_DIST_SCALE: r_dist_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_HEAD) begin
                r_heading <= r_heading + turn_sum[HEADING_BITS+TURN_SHIFT-1:TURN_SHIFT];
            end
            if (r_state == ST_XUPD) begin
                r_pos_x <= upd_sat;
            end
            if (r_state == ST_YUPD) begin
                r_pos_y <= upd_sat;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum  <= SUM_W'(left_ticks) + SUM_W'(right_ticks);
            r_diff <= SUM_W'(left_ticks) - SUM_W'(right_ticks);
            r_op   <= i_s_axis_tuser;
        end
        if (r_state == ST_DIST) begin
            r_dist <= prod[DIST_W-1:0];
        end
        if (r_state == ST_XHI || r_state == ST_YHI) begin
            r_acc <= ACC_W'(prod) + DELTA_ROUND;
        end
        if (r_state == ST_XACC || r_state == ST_YACC) begin
            r_acc <= r_acc + (ACC_W'(prod) <<< DIST_LO_W);
        end
        if (out_load) begin
            r_m_tdata <= OUT_W'({r_heading, r_pos_y, r_pos_x});
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) accept |=> !o_s_axis_tready
    ) else $error("input accepted again while an item is in progress");

    a_heading_only_skips: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HEAD && !move) |=> (r_state == ST_OUT)
    ) else $error("heading-only item did not go straight to the result");

    a_cordic_done_in_rot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cordic_done |-> (r_state == ST_ROT)
    ) else $error("rotation finished outside its waiting state");

    a_heading_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != ST_HEAD) |=> $stable(r_heading)
    ) else $error("heading changed outside its update step");

    a_pos_x_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != ST_XUPD) |=> $stable(r_pos_x)
    ) else $error("x position changed outside its update step");

endmodule

// ===== sim/tb_differential_drive_odometry.sv =====
module tb_differential_drive_odometry;

    import ddo_pkg::*;

    localparam int IN_W  = 32;
    localparam int OUT_W = 80;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 48;

    localparam longint POS_MAX     = 2147483647;
    localparam longint POS_MIN     = -POS_MAX - 1;
    localparam longint DELTA_ROUND = 64'sh20_0000_0000;

    // Arctangent of 2^-i in turns, 2^32 to a full turn.
    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
        32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        heading;
    } t_pose;

    class pose_tracker;
        logic [SCALE_W-1:0] turn_scale;
        logic [SCALE_W-1:0] distance_scale;
        longint             pos_x;
        longint             pos_y;
        logic [15:0]        heading;
        t_pose              pending[$];
        int                 mismatches;
        int                 poses_checked;
        int                 clamp_hits;
        int                 op_count[4];

        function new();
            turn_scale     = TURN_SCALE_RESET;
            distance_scale = DIST_SCALE_RESET;
            pos_x          = 0;
            pos_y          = 0;
            heading        = '0;
            mismatches     = 0;
            poses_checked  = 0;
            clamp_hits     = 0;
            op_count       = '{0, 0, 0, 0};
        endfunction

        function void set_scale(logic index, logic [SCALE_W-1:0] value);
            if (index == CFG_TURN_SCALE) begin
                turn_scale = value;
            end else begin
                distance_scale = value;
            end
        endfunction

        function longint clamp_position(longint v);
            if (v > POS_MAX) begin
                clamp_hits++;
                return POS_MAX;
            end
            if (v < POS_MIN) begin
                clamp_hits++;
                return POS_MIN;
            end
            return v;
        endfunction

        // Cosine and sine of a heading in Q22, by a 24-step rotation.
        function void heading_trig(logic [15:0] hd, output longint c, output longint s);
            logic [31:0] a;
            logic [31:0] probe;
            logic        flip;
            longint      x, y, z, dx, dy;
            a     = {hd, 16'h0000};
            probe = a + QUARTER_TURN;
            flip  = probe[31];
            // The second and third quarters are rotated by half a turn first.
            if (flip) begin
                a = a + 32'h8000_0000;
            end
            z = $signed(a);
            x = longint'(CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURNS[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURNS[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = x >>> TRIG_SHIFT;
            s = y >>> TRIG_SHIFT;
        endfunction

        function void record_ticks(logic signed [15:0] left, logic signed [15:0] right,
                                   logic [OP_W-1:0] op);
            longint diff, turn, travel, c, s, dx, dy;
            t_pose  p;
            op_count[op]++;
            diff    = longint'(left) - longint'(right);
            turn    = (diff * longint'(turn_scale) + 32768) >>> TURN_SHIFT;
            heading = heading + turn[15:0];
            if (op == OP_ADVANCE || op == OP_RETRACT) begin
                travel = (longint'(left) + longint'(right)) * longint'(distance_scale);
                heading_trig(heading, c, s);
                dx = (travel * c + DELTA_ROUND) >>> DELTA_SHIFT;
                dy = -((travel * s + DELTA_ROUND) >>> DELTA_SHIFT);
                if (op == OP_ADVANCE) begin
                    pos_x = clamp_position(pos_x + dx);
                    pos_y = clamp_position(pos_y + dy);
                end else begin
                    pos_x = clamp_position(pos_x - dx);
                    pos_y = clamp_position(pos_y - dy);
                end
            end
            p.x       = pos_x[31:0];
            p.y       = pos_y[31:0];
            p.heading = heading;
            pending.push_back(p);
        endfunction

        function void compare_pose(logic [OUT_W-1:0] word);
            t_pose want;
            if (pending.size() == 0) begin
                $error("pose transfer with no input outstanding, data %h", word);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            poses_checked++;
            if (word[31:0] !== want.x) begin
                $error("x_position expected %0d actual %0d", want.x, $signed(word[31:0]));
                mismatches++;
            end
            if (word[63:32] !== want.y) begin
                $error("y_position expected %0d actual %0d", want.y, $signed(word[63:32]));
                mismatches++;
            end
            if (word[79:64] !== want.heading) begin
                $error("heading expected %0d actual %0d", want.heading, word[79:64]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = CFG_TURN_SCALE;
    logic [SCALE_W-1:0]   i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    logic [OP_W-1:0]      i_s_axis_tuser = OP_ADVANCE;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;

    pose_tracker tracker = new();
    logic        steady = 1'b0;
    int          quiet_cycles = 0;

    differential_drive_odometry dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= 16);
    end

    // Both transfer monitors and the watchdog sample the values held across the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tracker.record_ticks(i_s_axis_tdata[15:0], i_s_axis_tdata[31:16],
                                     i_s_axis_tuser);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                tracker.compare_pose(o_m_axis_tdata);
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL differential_drive_odometry");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_ticks(input logic signed [15:0] left, input logic signed [15:0] right,
                              input logic [OP_W-1:0] op);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {right, left};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic sender_gap(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if (!steady && $urandom_range(99) < 16) begin
            sender_gap($urandom_range(4, 1));
        end
    endtask

    task automatic wait_for_poses();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending.size() != 0);
    endtask

    task automatic write_scales(input logic [SCALE_W-1:0] turn,
                                input logic [SCALE_W-1:0] distance);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TURN_SCALE;
        i_cfg_data  <= turn;
        @(posedge i_clk);
        tracker.set_scale(CFG_TURN_SCALE, turn);
        i_cfg_index <= CFG_DIST_SCALE;
        i_cfg_data  <= distance;
        @(posedge i_clk);
        tracker.set_scale(CFG_DIST_SCALE, distance);
        i_cfg_we <= 1'b0;
    endtask

    task automatic change_setting(input logic [SCALE_W-1:0] turn,
                                  input logic [SCALE_W-1:0] distance);
        wait_for_poses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_scales(turn, distance);
    endtask

    // Only valid while the turn scale is one heading unit per tick of difference.
    task automatic steer_heading(input logic [15:0] target);
        logic [15:0] step;
        int          left;
        step = target - tracker.heading;
        left = int'(step) - 32768;
        send_ticks(16'(left), -16'sd32768, OP_HEADING);
    endtask

    function automatic logic signed [15:0] pick_tick();
        case ($urandom_range(9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3, 4: return 16'($urandom_range(16'hFFFF));
            default: return 16'(int'($urandom_range(800)) - 400);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return OP_ADVANCE;
        if (roll < 70) return OP_RETRACT;
        if (roll < 90) return OP_HEADING;
        return OP_UNUSED;
    endfunction

    task automatic random_item();
        logic signed [15:0] left, right;
        left = pick_tick();
        // Half of the items model a vehicle in motion: the two wheels turn at similar rates.
        if ($urandom_range(1)) begin
            right = left + 16'(int'($urandom_range(64)) - 32);
        end else begin
            right = pick_tick();
        end
        if ($urandom_range(63) == 0) begin
            wait_for_poses();
        end
        maybe_pause();
        send_ticks(left, right, pick_op());
    endtask

    task automatic drive_straight(input logic [OP_W-1:0] op);
        logic signed [15:0] ticks;
        ticks = 16'($urandom_range(32767, 31000));
        maybe_pause();
        send_ticks(ticks, ticks, op);
    endtask

    initial begin
        logic [SCALE_W-1:0] turn_val, dist_val;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of the tick fields and every mode, at the reset scales.
        send_ticks(16'sd0, 16'sd0, OP_ADVANCE);
        send_ticks(16'sd32767, 16'sd32767, OP_ADVANCE);
        send_ticks(-16'sd32768, -16'sd32768, OP_RETRACT);
        send_ticks(16'sd32767, -16'sd32768, OP_HEADING);
        send_ticks(-16'sd32768, 16'sd32767, OP_HEADING);
        send_ticks(-16'sd32768, 16'sd32767, OP_ADVANCE);
        send_ticks(16'sd1, -16'sd1, OP_UNUSED);
        send_ticks(16'sd100, 16'sd300, OP_UNUSED);
        send_ticks(-16'sd1, -16'sd1, OP_ADVANCE);
        send_ticks(16'sd21845, -16'sd21846, OP_ADVANCE);
        send_ticks(-16'sd21846, 16'sd21845, OP_RETRACT);

        // Headings on and beside the quadrant boundaries of the rotation.
        change_setting(20'd65536, DIST_SCALE_RESET);
        steer_heading(16'h3FFF);
        send_ticks(16'sd1000, 16'sd1000, OP_ADVANCE);
        steer_heading(16'h4000);
        send_ticks(16'sd1000, 16'sd1000, OP_ADVANCE);
        steer_heading(16'h8000);
        send_ticks(16'sd1000, 16'sd1000, OP_RETRACT);
        steer_heading(16'hC000);
        send_ticks(16'sd1000, 16'sd1000, OP_ADVANCE);
        steer_heading(16'hFFFF);
        send_ticks(16'sd1000, 16'sd1000, OP_ADVANCE);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    turn_val = TURN_SCALE_RESET;
                    dist_val = DIST_SCALE_RESET;
                end
                1: begin
                    turn_val = '0;
                    dist_val = '1;
                end
                2: begin
                    turn_val = '1;
                    dist_val = '0;
                end
                3: begin
                    turn_val = 20'd1;
                    dist_val = 20'd1;
                end
                default: begin
                    turn_val = SCALE_W'($urandom_range(20'hFFFFF));
                    dist_val = SCALE_W'($urandom_range(20'hFFFFF));
                end
            endcase
            change_setting(turn_val, dist_val);
            repeat (210) random_item();
        end

        // Straight runs at full scale give the largest position steps, along x, then along y.
        change_setting(20'd65536, '1);
        steady = 1'b1;
        steer_heading(16'h0000);
        repeat (250) drive_straight(OP_ADVANCE);
        steady = 1'b0;
        steer_heading(16'h4000);
        repeat (250) drive_straight(OP_ADVANCE);
        repeat (20) drive_straight(OP_RETRACT);

        wait_for_poses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.pending.size() != 0) begin
            $error("%0d pose results never arrived", tracker.pending.size());
            tracker.mismatches++;
        end

        $display("Covered %0d advance, %0d retract, %0d heading-only and %0d unused-mode updates",
                 tracker.op_count[OP_ADVANCE], tracker.op_count[OP_RETRACT],
                 tracker.op_count[OP_HEADING], tracker.op_count[OP_UNUSED]);
        $display("over the reset, edge and random scales; %0d poses checked, %0d clamps predicted.",
                 tracker.poses_checked, tracker.clamp_hits);
        if (tracker.mismatches == 0) begin
            $display("PASS differential_drive_odometry");
        end else begin
            $display("FAIL differential_drive_odometry");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_cordic.sv
hw/rtl/differential_drive_odometry.sv
sim/tb_differential_drive_odometry.sv
